// ----- hw/rtl/mrt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants of the mask resample/threshold block.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int SIZE_W    = 13;
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 9;
  localparam int K_W       = 4;
  localparam int JOB_DEPTH = 4;
  localparam int PTR_W     = $clog2(JOB_DEPTH);
  localparam int LEVEL_W   = $clog2(JOB_DEPTH + 1);

  localparam logic REG_SOURCE_WIDTH  = 1'b0;
  localparam logic REG_SOURCE_HEIGHT = 1'b1;

  localparam logic [PIX_W-1:0] MASK_ON  = 8'd255;
  localparam logic [PIX_W-1:0] MASK_OFF = 8'd0;

  // per-axis box status of the current source position
  typedef struct packed {
    logic has1;    // second target box also holds the position
    logic emit0;   // position is the last of the lower box
    logic emit1;   // position is the last of the upper box
    logic first0;  // position is the first of the lower box
    logic first1;  // position is the first of the upper box
    logic last;    // last position of the line
    logic max0;    // lower box is the last target index
    logic max1;    // upper box is the last target index
  } axis_flags_t;

  // results caused by one item; slot order y0x0, y0x1, y1x0, y1x1
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [1:0]         mask;
    logic [3:0]         slots;
    logic [3:0]         fend;
  } job_t;

  // smallest k with 2**k >= s
  function automatic logic [K_W-1:0] size_log(input logic [SIZE_W-1:0] s);
    logic [K_W-1:0] k;
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (({{SIZE_W{1'b0}}, 1'b1} << i) < {1'b0, s}) begin
        k = K_W'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

// ----- hw/rtl/mrt_ifs.sv -----
// ----------------------------------------------------------------------------
// mrt_ifs
// Valid/ready channels: source pixels in, mask pixels out.
// ----------------------------------------------------------------------------
interface mrt_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [mrt_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mrt_mask_if;
  logic                        valid;
  logic                        ready;
  logic [mrt_pkg::COORD_W-1:0] out_x;
  logic [mrt_pkg::COORD_W-1:0] out_y;
  logic [mrt_pkg::PIX_W-1:0]   mask_value;
  logic                        last_of_run;
  logic                        frame_end;

  modport source (output valid, output out_x, output out_y, output mask_value,
                  output last_of_run, output frame_end, input ready);
  modport sink   (input valid, input out_x, input out_y, input mask_value,
                  input last_of_run, input frame_end, output ready);
endinterface

// ----- hw/rtl/mrt_ram.sv -----
// ----------------------------------------------------------------------------
// mrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mrt_axis.sv -----
// ----------------------------------------------------------------------------
// mrt_axis
// Tracks the source position on one axis and the lowest target box holding
// it; box bounds come from a running t*size product shifted by log2(target).
// ----------------------------------------------------------------------------
module mrt_axis #(
  parameter int LOG = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic                         step,
  input  logic [mrt_pkg::SIZE_W-1:0]   size,
  input  logic [mrt_pkg::K_W-1:0]      k,
  output logic [LOG-1:0]               t,
  output mrt_pkg::axis_flags_t         flags
);

  localparam int AW = mrt_pkg::SIZE_W + LOG + 1;
  localparam int EW = mrt_pkg::SIZE_W + 1;

  logic [mrt_pkg::SIZE_W-1:0] pos, pos_next;
  logic [LOG-1:0]             t_next, t1, tl;
  logic [AW-1:0]              acc, acc_next, a1, a2;
  logic [EW-1:0]              s0, s1, s2, e0, e1, p, pn;
  logic [LOG:0]               tl_w;
  logic                       more, in0, in1;

  always_comb begin
    a1    = acc + AW'(size);
    a2    = a1 + AW'(size);
    s0    = EW'(acc >> k);
    s1    = EW'(a1 >> k);
    s2    = EW'(a2 >> k);
    e0    = (s1 > s0) ? s1 : s0 + EW'(1);
    e1    = (s2 > s1) ? s2 : s1 + EW'(1);
    tl_w  = ((LOG+1)'(1) << k) - (LOG+1)'(1);
    tl    = tl_w[LOG-1:0];
    t1    = t + LOG'(1);
    more  = t < tl;
    p     = EW'(pos);
    pn    = p + EW'(1);
    in0   = pn < e0;
    in1   = more && (s1 <= pn) && (pn < e1);

    flags.has1   = more && (s1 <= p) && (p < e1);
    flags.emit0  = (e0 - EW'(1)) == p;
    flags.emit1  = flags.has1 && ((e1 - EW'(1)) == p);
    flags.first0 = s0 == p;
    flags.first1 = flags.has1 && (s1 == p);
    flags.last   = pos == (size - mrt_pkg::SIZE_W'(1));
    flags.max0   = t == tl;
    flags.max1   = more && (t1 == tl);

    pos_next = pos;
    t_next   = t;
    acc_next = acc;
    if (step) begin
      if (flags.last) begin
        pos_next = '0;
        t_next   = '0;
        acc_next = '0;
      end else begin
        pos_next = pos + mrt_pkg::SIZE_W'(1);
        if (in0) begin
          t_next = t;
        end else if (in1) begin
          t_next   = t1;
          acc_next = a1;
        end else begin
          t_next   = t + LOG'(2);
          acc_next = a2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos <= '0;
      t   <= '0;
      acc <= '0;
    end else begin
      pos <= pos_next;
      t   <= t_next;
      acc <= acc_next;
    end
  end

endmodule

// ----- hw/rtl/mrt_front.sv -----
// ----------------------------------------------------------------------------
// mrt_front
// Accepts pixels, finds their target boxes, accumulates column sums in two
// banks (even/odd target column) and hands finished boxes on as jobs.
// ----------------------------------------------------------------------------
module mrt_front #(
  parameter int LOG = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mrt_pkg::SIZE_W-1:0]    cfg_data,
  mrt_pixel_if.sink                     pix_in,
  input  logic [mrt_pkg::LEVEL_W-1:0]   level,
  output logic                          push,
  output mrt_pkg::job_t                 job
);

  localparam int BAW   = (LOG > 1) ? LOG - 1 : 1;
  localparam int BOX   = ((1 << mrt_pkg::SIZE_W) - 1 + (1 << LOG) - 1) >> LOG;
  localparam int CNT_W = $clog2(BOX * BOX + 1);
  localparam int SUM_W = CNT_W + mrt_pkg::PIX_W;
  localparam int ENT_W = SUM_W + CNT_W;

  logic [mrt_pkg::SIZE_W-1:0] src_w, src_h, cfg_eff;
  logic [mrt_pkg::K_W-1:0]    kx, ky, cfg_k, cfg_k_raw;
  logic                       accept, row_fresh;
  logic [LOG-1:0]             tx, ty, tx1;
  mrt_pkg::axis_flags_t       xf, yf;

  logic [1:0][BAW-1:0]        rd_addr;
  logic [1:0]                 lane_we, lane_fresh;

  logic                       b_valid, b_swap;
  logic [mrt_pkg::PIX_W-1:0]  b_pixel;
  logic [1:0][BAW-1:0]        b_addr;
  logic [1:0]                 b_we, b_fresh;
  logic [3:0]                 b_slots, b_fend;
  logic [LOG-1:0]             b_x0, b_y0;

  logic [1:0][ENT_W-1:0]      rd_data, ent_new, lw_data;
  logic [1:0][BAW-1:0]        lw_addr;
  logic [1:0]                 lw_valid, bank_mask;

  // configuration
  always_comb begin
    cfg_eff   = (cfg_data == '0) ? mrt_pkg::SIZE_W'(1) : cfg_data;
    cfg_k_raw = mrt_pkg::size_log(cfg_eff);
    cfg_k     = (cfg_k_raw > mrt_pkg::K_W'(LOG)) ? mrt_pkg::K_W'(LOG) : cfg_k_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= mrt_pkg::SIZE_W'(1);
      src_h <= mrt_pkg::SIZE_W'(1);
      kx    <= '0;
      ky    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrt_pkg::REG_SOURCE_WIDTH: begin
          src_w <= cfg_eff;
          kx    <= cfg_k;
        end
        mrt_pkg::REG_SOURCE_HEIGHT: begin
          src_h <= cfg_eff;
          ky    <= cfg_k;
        end
        default: ;
      endcase
    end
  end

  assign pix_in.ready = (level + mrt_pkg::LEVEL_W'(b_valid))
                        < mrt_pkg::LEVEL_W'(mrt_pkg::JOB_DEPTH);
  assign accept = pix_in.valid && pix_in.ready;

  mrt_axis #(.LOG(LOG)) u_axis_x (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .step    (accept),
    .size    (src_w),
    .k       (kx),
    .t       (tx),
    .flags   (xf)
  );

  mrt_axis #(.LOG(LOG)) u_axis_y (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .step    (accept && xf.last),
    .size    (src_h),
    .k       (ky),
    .t       (ty),
    .flags   (yf)
  );

  // a row right after a row that emitted starts every column box afresh
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_fresh <= 1'b1;
    end else if (accept && xf.last) begin
      row_fresh <= yf.emit0 || yf.emit1;
    end
  end

  // lane 0 is target column tx, lane 1 is tx+1; they sit in opposite banks
  always_comb begin
    tx1           = tx + LOG'(1);
    lane_we[0]    = 1'b1;
    lane_we[1]    = xf.has1;
    lane_fresh[0] = row_fresh && xf.first0;
    lane_fresh[1] = row_fresh && xf.first1;
    rd_addr[0]    = tx[0] ? BAW'(tx1 >> 1) : BAW'(tx >> 1);
    rd_addr[1]    = tx[0] ? BAW'(tx >> 1) : BAW'(tx1 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pixel    <= pix_in.pixel;
      b_swap     <= tx[0];
      b_addr     <= rd_addr;
      b_we[0]    <= tx[0] ? lane_we[1] : lane_we[0];
      b_we[1]    <= tx[0] ? lane_we[0] : lane_we[1];
      b_fresh[0] <= tx[0] ? lane_fresh[1] : lane_fresh[0];
      b_fresh[1] <= tx[0] ? lane_fresh[0] : lane_fresh[1];
      b_slots    <= {yf.emit1 & xf.emit1, yf.emit1 & xf.emit0,
                     yf.emit0 & xf.emit1, yf.emit0 & xf.emit0};
      b_fend     <= {yf.max1 & xf.max1, yf.max1 & xf.max0,
                     yf.max0 & xf.max1, yf.max0 & xf.max0};
      b_x0       <= tx;
      b_y0       <= ty;
    end
  end

  for (genvar bk = 0; bk < 2; bk++) begin : g_bank
    logic [ENT_W-1:0] old;
    logic [SUM_W-1:0] base_sum, new_sum;
    logic [CNT_W-1:0] base_cnt, new_cnt;

    mrt_ram #(.WIDTH(ENT_W), .DEPTH(1 << BAW)) u_ram (
      .clk   (clk),
      .we    (b_valid && b_we[bk]),
      .waddr (b_addr[bk]),
      .wdata (ent_new[bk]),
      .raddr (rd_addr[bk]),
      .rdata (rd_data[bk])
    );

    always_comb begin
      old = (lw_valid[bk] && (lw_addr[bk] == b_addr[bk])) ? lw_data[bk] : rd_data[bk];
      base_sum      = b_fresh[bk] ? '0 : old[ENT_W-1:CNT_W];
      base_cnt      = b_fresh[bk] ? '0 : old[CNT_W-1:0];
      new_sum       = base_sum + SUM_W'(b_pixel);
      new_cnt       = base_cnt + CNT_W'(1);
      ent_new[bk]   = {new_sum, new_cnt};
      bank_mask[bk] = new_sum >= (SUM_W'(new_cnt) << 7);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lw_valid[bk] <= 1'b0;
      end else if (b_valid && b_we[bk]) begin
        lw_valid[bk] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (b_valid && b_we[bk]) begin
        lw_addr[bk] <= b_addr[bk];
        lw_data[bk] <= ent_new[bk];
      end
    end
  end

  always_comb begin
    push       = b_valid && (b_slots != '0);
    job.x0     = mrt_pkg::COORD_W'(b_x0);
    job.y0     = mrt_pkg::COORD_W'(b_y0);
    job.mask   = b_swap ? {bank_mask[0], bank_mask[1]} : bank_mask;
    job.slots  = b_slots;
    job.fend   = b_fend;
  end

endmodule

// ----- hw/rtl/mrt_fifo.sv -----
// ----------------------------------------------------------------------------
// mrt_fifo
// Short show-ahead job queue between front and back.
// ----------------------------------------------------------------------------
module mrt_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mrt_pkg::job_t                 job_in,
  input  logic                          pop,
  output logic                          head_valid,
  output mrt_pkg::job_t                 head,
  output logic [mrt_pkg::LEVEL_W-1:0]   level
);

  mrt_pkg::job_t                mem [mrt_pkg::JOB_DEPTH];
  logic [mrt_pkg::PTR_W-1:0]    wp, rp;
  logic [mrt_pkg::LEVEL_W-1:0]  count;

  assign head       = mem[rp];
  assign head_valid = count != '0;
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + mrt_pkg::PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + mrt_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + mrt_pkg::LEVEL_W'(1);
      end else if (pop && !push) begin
        count <= count - mrt_pkg::LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= job_in;
    end
  end

endmodule

// ----- hw/rtl/mrt_back.sv -----
// ----------------------------------------------------------------------------
// mrt_back
// Expands each job into its mask pixels, one per cycle while mask_out is ready,
// into an output register.
// ----------------------------------------------------------------------------
module mrt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  mrt_pkg::job_t  head,
  output logic           pop,
  mrt_mask_if.source     mask_out
);

  logic [3:0]                  done, pending, onehot, rest;
  logic [1:0]                  sel;
  logic                        load;
  logic                        o_valid, o_last, o_fend;
  logic [mrt_pkg::COORD_W-1:0] o_x, o_y;
  logic [mrt_pkg::PIX_W-1:0]   o_mask;

  always_comb begin
    pending = head.slots & ~done;
    sel     = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (pending[i]) begin
        sel = 2'(i);
      end
    end
    onehot = 4'b0001 << sel;
    rest   = pending & ~onehot;
    load   = head_valid && (!o_valid || mask_out.ready);
    pop    = load && (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      done    <= '0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
        done    <= (rest == '0) ? '0 : (done | onehot);
      end else if (mask_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_x    <= sel[0] ? head.x0 + mrt_pkg::COORD_W'(1) : head.x0;
      o_y    <= sel[1] ? head.y0 + mrt_pkg::COORD_W'(1) : head.y0;
      o_mask <= head.mask[sel[0]] ? mrt_pkg::MASK_ON : mrt_pkg::MASK_OFF;
      o_last <= rest == '0;
      o_fend <= head.fend[sel];
    end
  end

  assign mask_out.valid       = o_valid;
  assign mask_out.out_x       = o_x;
  assign mask_out.out_y       = o_y;
  assign mask_out.mask_value  = o_mask;
  assign mask_out.last_of_run = o_last;
  assign mask_out.frame_end   = o_fend;

endmodule

// ----- hw/rtl/mask_resample_threshold.sv -----
// ----------------------------------------------------------------------------
// mask_resample_threshold
// Resamples a raster-order grey image to a power-of-two binary mask.
//
// Write source_width (index 0) and source_height (index 1) on the cfg port
// while idle; any write restarts the frame at pixel (0,0). Pixels enter on
// pix_in (valid/ready), one per cycle when the queue has room. Each pixel
// that closes one or more target boxes yields up to four mask pixels on
// mask_out, lowest row first, then lowest column; last_of_run marks the
// final one of a pixel and frame_end the bottom-right mask pixel.
// Items are taken one per cycle while each closes at most one box and
// mask_out is ready; the output register sends one mask pixel per cycle
// while mask_out is ready. Box sums live in two RAM banks (even/odd target
// column), each read once and written at most once per item.
// Reset puts both sizes at 1 and the position at (0,0); no clearing pass is
// needed. A stalled receiver fills the four-entry job queue, then pix_in
// drops ready.
// ----------------------------------------------------------------------------
module mask_resample_threshold #(
  parameter int MAX_SIDE_LOG2 = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mrt_pkg::SIZE_W-1:0]  cfg_data,
  mrt_pixel_if.sink                   pix_in,
  mrt_mask_if.source                  mask_out
);

  logic                         push, pop, head_valid;
  mrt_pkg::job_t                job, head;
  logic [mrt_pkg::LEVEL_W-1:0]  level;

  mrt_front #(.LOG(MAX_SIDE_LOG2)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .level     (level),
    .push      (push),
    .job       (job)
  );

  mrt_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  mrt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .mask_out   (mask_out)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < mrt_pkg::LEVEL_W'(mrt_pkg::JOB_DEPTH)))
    else $error("job queue overflow");

  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    (mask_out.valid && mask_out.frame_end) |-> mask_out.last_of_run)
    else $error("frame end not on last result of item");

  a_mask_binary: assert property (@(posedge clk) disable iff (rst)
    mask_out.valid |-> (mask_out.mask_value == mrt_pkg::MASK_ON ||
                        mask_out.mask_value == mrt_pkg::MASK_OFF))
    else $error("mask value not binary");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (head.slots != '0))
    else $error("pop of empty queue or empty job");

endmodule

// ----- bench/mask_resample_threshold_tb.sv -----
// ----------------------------------------------------------------------------
// mask_resample_threshold_tb
// Streams grey frames of many sizes through the mask resampler and checks
// every mask pixel against a predictor of the box sums and thresholds.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module mask_resample_threshold_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_CAP = 512;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [mrt_pkg::COORD_W-1:0] x;
    logic [mrt_pkg::COORD_W-1:0] y;
    logic [mrt_pkg::PIX_W-1:0]   value;
    logic                        last;
    logic                        fend;
  } mask_px_t;

  class mask_scoreboard;
    int unsigned src_w, src_h;
    int unsigned box_sum[SIDE_CAP];
    int unsigned box_cnt[SIDE_CAP];
    int unsigned col, row;
    mask_px_t pending[$];
    int errors;

    function new();
      src_w = 1;
      src_h = 1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < SIDE_CAP; i++) begin
        box_sum[i] = 0;
        box_cnt[i] = 0;
      end
      col = 0;
      row = 0;
    endfunction

    function void configure(logic idx, logic [mrt_pkg::SIZE_W-1:0] val);
      if (idx == mrt_pkg::REG_SOURCE_WIDTH) src_w = val;
      else src_h = val;
      restart();
    endfunction

    function int unsigned tsize(int unsigned s);
      int unsigned t;
      t = 1;
      while (t < s && t < SIDE_CAP) t <<= 1;
      return t;
    endfunction

    function int unsigned bstart(int unsigned t, int unsigned s, int unsigned n);
      return (t * s) / n;
    endfunction

    function int unsigned bend(int unsigned t, int unsigned s, int unsigned n);
      int unsigned b, e;
      b = bstart(t, s, n);
      e = ((t + 1) * s) / n;
      return (e < b + 1) ? b + 1 : e;
    endfunction

    function bit holds(int unsigned t, int unsigned c, int unsigned s, int unsigned n);
      return bstart(t, s, n) <= c && c < bend(t, s, n);
    endfunction

    function int unsigned lowest(int unsigned c, int unsigned s, int unsigned n);
      int unsigned t;
      t = ((c + 1) * n - 1) / s;
      if (t > n - 1) t = n - 1;
      if (t > 0 && holds(t - 1, c, s, n)) t--;
      return t;
    endfunction

    function void note_pixel(logic [mrt_pkg::PIX_W-1:0] p);
      int unsigned w, h, tw, th, nx, ny, n;
      int unsigned xs[2], ys[2];
      mask_px_t m;
      w = (src_w == 0) ? 1 : src_w;
      h = (src_h == 0) ? 1 : src_h;
      tw = tsize(w);
      th = tsize(h);
      n = 0;
      if (col >= w || row >= h) begin
        col = 0;
        row = 0;
      end
      nx = 1;
      xs[0] = lowest(col, w, tw);
      if (xs[0] + 1 < tw && holds(xs[0] + 1, col, w, tw)) begin
        xs[1] = xs[0] + 1;
        nx = 2;
      end
      for (int i = 0; i < nx; i++) begin
        box_sum[xs[i]] += p;
        box_cnt[xs[i]] += 1;
      end
      ny = 1;
      ys[0] = lowest(row, h, th);
      if (ys[0] + 1 < th && holds(ys[0] + 1, row, h, th)) begin
        ys[1] = ys[0] + 1;
        ny = 2;
      end
      for (int j = 0; j < ny; j++) begin
        if (bend(ys[j], h, th) - 1 == row) begin
          for (int i = 0; i < nx; i++) begin
            if (bend(xs[i], w, tw) - 1 == col) begin
              m.x = xs[i][mrt_pkg::COORD_W-1:0];
              m.y = ys[j][mrt_pkg::COORD_W-1:0];
              m.value = (box_sum[xs[i]] >= 128 * box_cnt[xs[i]]) ?
                        mrt_pkg::MASK_ON : mrt_pkg::MASK_OFF;
              m.last = 1'b0;
              m.fend = (xs[i] == tw - 1 && ys[j] == th - 1);
              pending.push_back(m);
              n++;
            end
          end
        end
      end
      if (n > 0) begin
        pending[$].last = 1'b1;
        for (int i = 0; i < nx; i++) begin
          if (bend(xs[i], w, tw) - 1 == col) begin
            box_sum[xs[i]] = 0;
            box_cnt[xs[i]] = 0;
          end
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_result(mask_px_t got);
      mask_px_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected mask pixel x=%0d y=%0d v=%0d", $time,
                 got.x, got.y, got.value);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.x !== exp.x || got.y !== exp.y || got.value !== exp.value ||
          got.last !== exp.last || got.fend !== exp.fend) begin
        $display("%0t: expected x=%0d y=%0d v=%0d last=%0b fend=%0b", $time,
                 exp.x, exp.y, exp.value, exp.last, exp.fend);
        $display("%0t:   actual x=%0d y=%0d v=%0d last=%0b fend=%0b", $time,
                 got.x, got.y, got.value, got.last, got.fend);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [mrt_pkg::SIZE_W-1:0] cfg_data;

  mrt_pixel_if pix();
  mrt_mask_if  msk();

  mask_resample_threshold u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix),
    .mask_out (msk)
  );

  mask_scoreboard sb;
  int idle_cycles;
  int stall_mode;
  int burst_left;
  bit pix_bias;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: msk.ready <= 1'b1;
      1: msk.ready <= ($urandom_range(0, 1) == 1);
      2: msk.ready <= ($urandom_range(0, 7) != 0);
      default: msk.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    mask_px_t got;
    if (!rst && msk.valid && msk.ready) begin
      got.x = msk.out_x;
      got.y = msk.out_y;
      got.value = msk.mask_value;
      got.last = msk.last_of_run;
      got.fend = msk.frame_end;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (msk.valid && msk.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mask_resample_threshold: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [mrt_pkg::SIZE_W-1:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    sb.configure(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_size(logic [mrt_pkg::SIZE_W-1:0] w, logic [mrt_pkg::SIZE_W-1:0] h);
    write_reg(mrt_pkg::REG_SOURCE_WIDTH, w);
    write_reg(mrt_pkg::REG_SOURCE_HEIGHT, h);
  endtask

  task automatic send_pixel(logic [mrt_pkg::PIX_W-1:0] p);
    if (burst_left == 0) begin
      pix.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    pix.valid = 1'b1;
    pix.pixel = p;
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(p);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [mrt_pkg::PIX_W-1:0] rand_pixel();
    if (pix_bias) return mrt_pkg::PIX_W'($urandom_range(0, 255));
    return mrt_pkg::PIX_W'($urandom_range(96, 160));
  endfunction

  task automatic send_frame_part(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    pix.valid = 1'b0;
  endtask

  initial begin
    int w, h, n;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mrt_pkg::REG_SOURCE_WIDTH;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    burst_left = 0;
    pix_bias = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset sizes: 1x1
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd127);
    send_pixel(8'd128);
    pix.valid = 1'b0;
    // zero sizes act as one
    set_size(13'd0, 13'd0);
    send_pixel(8'd200);
    send_pixel(8'd1);
    pix.valid = 1'b0;
    // 3x3 upsampled to 4x4: first row and column each fall in two boxes
    set_size(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
    send_pixel(8'd128);
    pix.valid = 1'b0;
    // widest sizes: partial rows only
    set_size(13'd8191, 13'd1);
    send_frame_part(6);
    set_size(13'd4096, 13'd8191);
    send_frame_part(4);

    // random phases, mostly small sizes
    for (int ph = 0; ph < 30; ph++) begin
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(513, 8191); h = $urandom_range(1, 3); end
        1: begin w = 1; h = $urandom_range(1, 12); end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
      endcase
      pix_bias = $urandom_range(0, 1);
      set_size(mrt_pkg::SIZE_W'(w), mrt_pkg::SIZE_W'(h));
      n = (w * h < 40) ? w * h + $urandom_range(0, w * h) : $urandom_range(5, 20);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 6);
      send_frame_part(n / 2);
      if (ph == 7) wait_drained();
      send_frame_part(n - n / 2);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("mask_resample_threshold: match");
    end else begin
      $display("mask_resample_threshold: mismatch");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/mrt_pkg.sv
hw/rtl/mrt_ifs.sv
hw/rtl/mrt_ram.sv
hw/rtl/mrt_axis.sv
hw/rtl/mrt_front.sv
hw/rtl/mrt_fifo.sv
hw/rtl/mrt_back.sv
hw/rtl/mask_resample_threshold.sv
bench/mask_resample_threshold_tb.sv
